[rtl/trb_pkg.sv]
// ----------------------------------------------------------------------------
// trb_pkg
// types and constants shared by the timestamp reorder buffer
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int unsigned TAG_W  = 16;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned HELD_W = 7;

    typedef enum logic [1:0] {
        KIND_ORDERED  = 2'd0,
        KIND_LATE     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    typedef enum logic {
        ACT_ARRIVAL = 1'b0,
        ACT_TICK    = 1'b1
    } t_action;

    localparam logic CFG_HOLD_TIMEOUT = 1'b0;
    localparam logic CFG_DROP_LATE    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_WRITE,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_MOVE,
        ST_TICK_WR,
        ST_OUT
    } t_state;

endpackage

[rtl/trb_if.sv]
// ----------------------------------------------------------------------------
// trb_in_if / trb_out_if / trb_cfg_if
// valid/ready channels of the timestamp reorder buffer
// ----------------------------------------------------------------------------
interface trb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] packet_tag;
    logic [47:0] capture_time;
    logic [47:0] now_time;
    modport source (output valid, action, packet_tag, capture_time, now_time, input ready);
    modport sink   (input valid, action, packet_tag, capture_time, now_time, output ready);
endinterface

interface trb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_tag;
    logic [47:0] out_time;
    logic [1:0]  kind;
    logic        last;
    logic [6:0]  held_count;
    logic [31:0] ordered_total;
    logic [31:0] late_total;
    modport source (output valid, out_tag, out_time, kind, last, held_count,
                    ordered_total, late_total, input ready);
    modport sink   (input valid, out_tag, out_time, kind, last, held_count,
                    ordered_total, late_total, output ready);
endinterface

interface trb_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/trb_cmp.sv]
// ----------------------------------------------------------------------------
// trb_cmp
// shared add and compare unit: due test and ordering test
// ----------------------------------------------------------------------------
module trb_cmp (
    input  logic [47:0] i_ts,
    input  logic [31:0] i_timeout,
    input  logic [47:0] i_now,
    input  logic [47:0] i_ref,
    output logic        o_due,
    output logic        o_greater
);
    logic [48:0] w_sum;

    assign w_sum     = {1'b0, i_ts} + {17'd0, i_timeout};
    assign o_due     = w_sum <= {1'b0, i_now};
    assign o_greater = i_ts > i_ref;
endmodule

[rtl/timestamp_reorder_buffer_core.sv]
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer_core
// reorders packet tags by capture timestamp in a sorted store
// ----------------------------------------------------------------------------
// arrival: classify (late, dropped, overflow end here), shift later stamps up, insert
// tick: test entries from the front, release each due tag, then move the rest down
// one result per cycle while releasing; a stalled output holds the block busy
// cost is set by the single store read port and the one shared compare unit
// synchronous active-low reset clears counters and fill, store is not cleared
module timestamp_reorder_buffer_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    trb_in_if.sink    in_ch,
    trb_out_if.source out_ch,
    trb_cfg_if.sink   cfg_ch
);
    import trb_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [63:0] mem [CAPACITY];
    logic [63:0] r_rd;

    t_state      r_state, n_state;
    logic [6:0]  r_fill, n_fill;
    logic [6:0]  r_pos, n_pos;
    logic [6:0]  r_due, n_due;
    logic [31:0] r_seq, n_seq, r_ord, n_ord, r_late, n_late;
    logic [31:0] r_timeout;
    logic        r_drop;
    logic [15:0] r_tag;
    logic [47:0] r_ts, r_now;

    logic        r_ovalid, n_ovalid;
    logic [15:0] r_otag, n_otag;
    logic [47:0] r_otime, n_otime;
    t_kind       r_okind, n_okind;
    logic        r_olast, n_olast;
    logic [6:0]  r_ohc, n_ohc;

    logic        w_we;
    logic [AW-1:0] w_wa, w_ra;
    logic [63:0] w_wd;
    logic [47:0] w_cts;
    logic        w_due, w_gt;
    logic [6:0]  w_pm1, w_pp1, w_mva;
    logic        w_ofree;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (r_state == ST_IDLE);

    assign out_ch.valid         = r_ovalid;
    assign out_ch.out_tag       = r_otag;
    assign out_ch.out_time      = r_otime;
    assign out_ch.kind          = r_okind;
    assign out_ch.last          = r_olast;
    assign out_ch.held_count    = r_ohc;
    assign out_ch.ordered_total = r_ord;
    assign out_ch.late_total    = r_late;

    assign w_pm1   = r_pos - 7'd1;
    assign w_pp1   = r_pos + 7'd1;
    assign w_mva   = r_pos + r_due;
    assign w_ofree = !r_ovalid || out_ch.ready;

    trb_cmp u_cmp (
        .i_ts     (w_cts),
        .i_timeout(r_timeout),
        .i_now    (r_now),
        .i_ref    (r_ts),
        .o_due    (w_due),
        .o_greater(w_gt)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rd <= mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 32'd1000000;
            r_drop    <= 1'b0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            if (cfg_ch.index == CFG_HOLD_TIMEOUT) r_timeout <= cfg_ch.data;
            else if (cfg_ch.index == CFG_DROP_LATE) r_drop <= cfg_ch.data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_seq    <= '0;
            r_ord    <= '0;
            r_late   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_seq    <= n_seq;
            r_ord    <= n_ord;
            r_late   <= n_late;
            r_ovalid <= n_ovalid;
        end
        r_pos   <= n_pos;
        r_due   <= n_due;
        r_otag  <= n_otag;
        r_otime <= n_otime;
        r_okind <= n_okind;
        r_olast <= n_olast;
        r_ohc   <= n_ohc;
        if (in_ch.valid && in_ch.ready) begin
            r_tag <= in_ch.packet_tag;
            r_ts  <= in_ch.capture_time;
            r_now <= in_ch.now_time;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_pos    = r_pos;
        n_due    = r_due;
        n_seq    = r_seq;
        n_ord    = r_ord;
        n_late   = r_late;
        n_ovalid = r_ovalid && !out_ch.ready;
        n_otag   = r_otag;
        n_otime  = r_otime;
        n_okind  = r_okind;
        n_olast  = r_olast;
        n_ohc    = r_ohc;
        w_we     = 1'b0;
        w_wa     = r_pos[AW-1:0];
        w_wd     = r_rd;
        w_ra     = r_pos[AW-1:0];
        w_cts    = r_ts;
        unique case (r_state)
            ST_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    if (in_ch.action == ACT_TICK) begin
                        n_pos   = '0;
                        n_due   = '0;
                        n_state = ST_TICK_RD;
                    end else begin
                        n_pos   = r_fill;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                // first pass: classify, later passes: shift one entry up
                w_cts = r_ts;
                w_ra  = w_pm1[AW-1:0];
                if (r_pos == r_fill && w_due) begin
                    if (r_drop) begin
                        n_seq   = r_seq + 32'd1;
                        n_state = ST_IDLE;
                    end else if (w_ofree) begin
                        n_seq    = r_seq + 32'd1;
                        n_late   = r_late + 32'd1;
                        n_ovalid = 1'b1;
                        n_otag = r_tag; n_otime = r_ts; n_okind = KIND_LATE;
                        n_olast = 1'b1; n_ohc = r_fill;
                        n_state = ST_IDLE;
                    end
                end else if (r_pos == r_fill && r_fill >= 7'(CAPACITY)) begin
                    if (w_ofree) begin
                        n_seq    = r_seq + 32'd1;
                        n_ovalid = 1'b1;
                        n_otag = r_tag; n_otime = r_ts; n_okind = KIND_OVERFLOW;
                        n_olast = 1'b1; n_ohc = r_fill;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_cts = r_rd[47:0];
                if (r_pos != 7'd0 && w_gt) begin
                    w_we    = 1'b1;
                    w_wd    = r_rd;
                    n_pos   = r_pos - 7'd1;
                    n_state = ST_SHIFT;
                end else begin
                    w_we    = 1'b1;
                    w_wd    = {r_tag, r_ts};
                    n_fill  = r_fill + 7'd1;
                    n_seq   = r_seq + 32'd1;
                    n_state = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                w_ra    = '0;
                n_state = (r_fill == 7'd0) ? ST_IDLE : ST_TICK_CHK;
            end
            ST_TICK_CHK: begin
                // count due entries from the front, one read per cycle
                w_cts = r_rd[47:0];
                if (w_due && w_pp1 < r_fill) begin
                    w_ra  = w_pp1[AW-1:0];
                    n_pos = w_pp1;
                    n_due = w_pp1;
                end else if (w_due || r_due != 7'd0) begin
                    n_due   = w_due ? w_pp1 : r_due;
                    n_pos   = '0;
                    w_ra    = '0;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                w_ra = r_pos[AW-1:0];
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_ord    = r_ord + 32'd1;
                    n_otag = r_rd[63:48]; n_otime = r_rd[47:0];
                    n_okind = KIND_ORDERED;
                    n_ohc   = r_fill - w_pp1;
                    n_olast = (w_pp1 == r_due);
                    n_pos   = w_pp1;
                    w_ra    = w_pp1[AW-1:0];
                    if (w_pp1 == r_due) begin
                        n_fill  = r_fill - r_due;
                        n_pos   = '0;
                        n_state = (r_fill == r_due) ? ST_IDLE : ST_TICK_MOVE;
                    end
                end
            end
            ST_TICK_MOVE: begin
                w_ra    = w_mva[AW-1:0];
                n_state = ST_TICK_WR;
            end
            ST_TICK_WR: begin
                w_we    = 1'b1;
                w_wa    = r_pos[AW-1:0];
                w_wd    = r_rd;
                n_pos   = w_pp1;
                n_state = (w_pp1 >= r_fill) ? ST_IDLE : ST_TICK_MOVE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[tb/sv/timestamp_reorder_buffer_core_tb.sv]
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer_core_tb
// drives arrivals and ticks into the reorder buffer, predicts every result
// and checks each output transfer, under several timeout and drop settings
// and several idling phases
// ----------------------------------------------------------------------------
module timestamp_reorder_buffer_core_tb;
    import trb_pkg::*;

    typedef struct packed {
        logic [15:0] tag;
        logic [47:0] tstamp;
        t_kind       kind;
        logic        last;
        logic [6:0]  held;
        logic [31:0] ordered;
        logic [31:0] late;
    } t_release;

    class reorder_scoreboard;
        logic [47:0] st_time [64];
        logic [15:0] st_tag [64];
        int          fill;
        logic [31:0] seq_cnt;
        logic [31:0] ord_cnt;
        logic [31:0] late_cnt;
        logic [31:0] timeout;
        logic        drop;
        t_release    pending [$];
        int          errors;

        function void clear();
            fill = 0;
            seq_cnt = 0;
            ord_cnt = 0;
            late_cnt = 0;
            timeout = 32'd1000000;
            drop = 1'b0;
            pending.delete();
            errors = 0;
        endfunction

        function bit is_due(logic [47:0] ts, logic [47:0] now);
            logic [48:0] s;
            s = {1'b0, ts} + {17'd0, timeout};
            return s <= {1'b0, now};
        endfunction

        function void note_input(logic act, logic [15:0] tag, logic [47:0] ts,
                                 logic [47:0] now);
            t_release r;
            int pos;
            int due;
            if (act == ACT_ARRIVAL) begin
                seq_cnt++;
                if (is_due(ts, now)) begin
                    if (drop) return;
                    late_cnt++;
                    r = '{tag, ts, KIND_LATE, 1'b1, 7'(fill), ord_cnt, late_cnt};
                    pending.push_back(r);
                    return;
                end
                if (fill >= 64) begin
                    r = '{tag, ts, KIND_OVERFLOW, 1'b1, 7'(fill), ord_cnt, late_cnt};
                    pending.push_back(r);
                    return;
                end
                pos = fill;
                while (pos > 0 && st_time[pos-1] > ts) begin
                    st_time[pos] = st_time[pos-1];
                    st_tag[pos] = st_tag[pos-1];
                    pos--;
                end
                st_time[pos] = ts;
                st_tag[pos] = tag;
                fill++;
            end else begin
                due = 0;
                while (due < fill && is_due(st_time[due], now)) due++;
                for (int i = 0; i < due; i++) begin
                    ord_cnt++;
                    r = '{st_tag[i], st_time[i], KIND_ORDERED, 1'(i + 1 == due),
                          7'(fill - i - 1), ord_cnt, late_cnt};
                    pending.push_back(r);
                end
                fill -= due;
                for (int j = 0; j < fill; j++) begin
                    st_time[j] = st_time[j+due];
                    st_tag[j] = st_tag[j+due];
                end
            end
        endfunction

        function void check_result(t_release got);
            t_release want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    trb_in_if  in_ch();
    trb_out_if out_ch();
    trb_cfg_if cfg_ch();

    timestamp_reorder_buffer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    reorder_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    int  quiet_cycles;
    logic [47:0] clock_now;
    logic [31:0] cur_timeout;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver side: random stall, check each output transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                board.check_result('{out_ch.out_tag, out_ch.out_time, t_kind'(out_ch.kind),
                    out_ch.last, out_ch.held_count, out_ch.ordered_total,
                    out_ch.late_total});
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("timestamp_reorder_buffer_core_tb: errors");
            $finish;
        end
    end

    // valid stays high after a transfer until the next item or an idle cycle
    task automatic send_item(logic act, logic [15:0] tag, logic [47:0] ts,
                             logic [47:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.packet_tag <= tag;
        in_ch.capture_time <= ts;
        in_ch.now_time <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_input(act, tag, ts, now);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_HOLD_TIMEOUT) begin
            board.timeout = val;
            cur_timeout = val;
        end else begin
            board.drop = val[0];
        end
    endtask

    // mostly near-future timestamps, some late, some far ahead
    task automatic random_item();
        logic [47:0] ts;
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            clock_now = clock_now + $urandom_range(cur_timeout > 2000 ? 2000 : 60);
            send_item(ACT_TICK, 16'($urandom), 48'({$urandom, $urandom}), clock_now);
        end else begin
            if (r < 45) ts = clock_now - $urandom_range(3000);
            else if (r < 50) ts = 48'({$urandom, $urandom});
            else ts = clock_now - $urandom_range(20) + $urandom_range(40);
            if ($urandom_range(9) == 0) ts = clock_now;
            send_item(ACT_ARRIVAL, 16'($urandom), ts, clock_now);
        end
    endtask

    initial begin
        board = new();
        board.clear();
        send_idle_pct = 0;
        stall_pct = 0;
        cur_timeout = 32'd1000000;
        clock_now = 48'd5000000;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_ARRIVAL;
        in_ch.packet_tag <= '0;
        in_ch.capture_time <= '0;
        in_ch.now_time <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_HOLD_TIMEOUT;
        cfg_ch.data <= '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes under reset settings, then under maximum timeout with late drop
        send_item(ACT_ARRIVAL, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_ARRIVAL, 16'h0000, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_ARRIVAL, 16'h0001, 48'd0, 48'd999999);
        send_item(ACT_ARRIVAL, 16'h0002, 48'd0, 48'd0);
        send_item(ACT_ARRIVAL, 16'h0003, 48'd5, 48'd0);
        send_item(ACT_TICK, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'd10);
        send_item(ACT_TICK, 16'h0, 48'd0, 48'd1000000);
        send_item(ACT_TICK, 16'h0, 48'd0, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_HOLD_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_DROP_LATE, 32'd1);
        send_item(ACT_ARRIVAL, 16'hAAAA, 48'hFFFF_0000_0000, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_ARRIVAL, 16'h5555, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(ACT_ARRIVAL, 16'h1234, 48'd0, 48'd0);
        send_item(ACT_TICK, 16'h0, 48'd0, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_HOLD_TIMEOUT, 32'd0);
        // equal timestamps keep arrival order
        send_item(ACT_ARRIVAL, 16'h0010, 48'd100, 48'd50);
        send_item(ACT_ARRIVAL, 16'h0011, 48'd100, 48'd50);
        send_item(ACT_ARRIVAL, 16'h0012, 48'd90, 48'd50);
        send_item(ACT_ARRIVAL, 16'h0013, 48'd100, 48'd50);
        send_item(ACT_TICK, 16'h0, 48'd0, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_DROP_LATE, 32'd0);
        send_item(ACT_ARRIVAL, 16'h0014, 48'd7, 48'd7);
        send_item(ACT_TICK, 16'h0, 48'd0, 48'hFFFF_FFFF_FFFF);

        // store full: fill with far-future stamps, then overflow
        for (int i = 0; i < 66; i++)
            send_item(ACT_ARRIVAL, 16'($urandom), 48'hF000_0000_0000 + $urandom_range(50),
                      48'd0);
        send_item(ACT_TICK, 16'h0, 48'd0, 48'hFFFF_FFFF_FFFF);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 75 : 0;
            stall_pct = (ph == 2) ? 75 : (ph == 3 ? 24 : 0);
            if (ph == 3) send_idle_pct = 24;
            case (ph)
                0: write_reg(CFG_HOLD_TIMEOUT, 32'd50);
                1: write_reg(CFG_HOLD_TIMEOUT, 32'd1000);
                2: write_reg(CFG_HOLD_TIMEOUT, 32'd0);
                default: write_reg(CFG_HOLD_TIMEOUT, 32'd20);
            endcase
            write_reg(CFG_DROP_LATE, 32'(ph == 1));
            for (int k = 0; k < 85; k++) random_item();
            clock_now = clock_now + 48'd100000;
            send_item(ACT_TICK, 16'h0, 48'd0, clock_now);
        end

        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("timestamp_reorder_buffer_core_tb: clean");
        else
            $display("timestamp_reorder_buffer_core_tb: errors");
        $finish;
    end
endmodule
